### sv/grep_line_match_filter_core_defines.svh
// Assertion macros shared by the line matcher modules.
`ifndef GREP_LINE_MATCH_FILTER_CORE_DEFINES_SVH
`define GREP_LINE_MATCH_FILTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define GLMF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: assertion failed");
// A condition that must never be seen outside reset.
`define GLMF_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define GLMF_ASSERT(lbl, clk, rstn, prop)
`define GLMF_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

### sv/glmf_pkg.sv
package glmf_pkg;

  localparam int PATTERN_MAX  = 16;
  localparam int WINDOW_DEPTH = PATTERN_MAX + 1;
  localparam int EVQ_DEPTH    = 4;
  localparam int CFG_IDX_W    = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_CASE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WHOLE_WORD   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT       = 3'd5;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    logic [15:0] line_number;
    logic        line_selected;
    logic [7:0]  occurrence_count;
  } out_item_t;

  typedef struct packed {
    logic [PATTERN_MAX-1:0][7:0] pattern;
    logic [4:0]                  pattern_length;
    logic                        ignore_case;
    logic                        whole_word;
    logic                        invert_select;
  } cfg_t;

  // Classified byte handed from the front end to the line tracker.
  typedef struct packed {
    logic word_byte;
    logic empty_pat;
    logic hit;
    logic left_ok;
    logic eol;
  } match_evt_t;

  function automatic logic is_word(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
    if (ic && c >= 8'h61 && c <= 8'h7A) begin
      return c - 8'd32;
    end
    return c;
  endfunction

endpackage

### sv/glmf_front.sv
`include "grep_line_match_filter_core_defines.svh"

module glmf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  glmf_pkg::cfg_t      cfg,
  input  logic                accept,
  input  glmf_pkg::in_item_t  item,
  output glmf_pkg::match_evt_t evt
);

  logic [7:0] recent_r [glmf_pkg::PATTERN_MAX];
  logic [4:0] bytes_r;
  logic [4:0] bytes_nxt;
  logic [7:0] win [glmf_pkg::WINDOW_DEPTH];
  logic [4:0] len_used;
  logic [glmf_pkg::PATTERN_MAX-1:0] pos_ok;

  // Window as it stands once the new byte has been shifted in.
  always_comb begin
    win[0] = item.text_byte;
    for (int k = 1; k < glmf_pkg::WINDOW_DEPTH; k++) begin
      win[k] = recent_r[k-1];
    end
  end

  assign len_used  = (cfg.pattern_length > 5'(glmf_pkg::PATTERN_MAX)) ?
                     5'(glmf_pkg::PATTERN_MAX) : cfg.pattern_length;
  assign bytes_nxt = (bytes_r < 5'(glmf_pkg::WINDOW_DEPTH)) ? bytes_r + 5'd1 : bytes_r;

  // Pattern byte i lines up with window slot len-1-i; unused bytes always agree.
  always_comb begin
    logic [4:0] idx;
    for (int i = 0; i < glmf_pkg::PATTERN_MAX; i++) begin
      idx = len_used - 5'd1 - 5'(i);
      pos_ok[i] = (5'(i) >= len_used) ||
                  (glmf_pkg::fold(win[{1'b0, idx[3:0]}], cfg.ignore_case) ==
                   glmf_pkg::fold(cfg.pattern[i], cfg.ignore_case));
    end
  end

  assign evt.word_byte = glmf_pkg::is_word(item.text_byte);
  assign evt.empty_pat = (len_used == 5'd0);
  assign evt.hit       = (len_used != 5'd0) && (bytes_nxt >= len_used) && (&pos_ok);
  assign evt.left_ok   = (bytes_nxt == len_used) || !glmf_pkg::is_word(win[len_used]);
  assign evt.eol       = item.end_of_line;

  // Window history; its count restarts at each line end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_r <= '0;
    end else if (accept) begin
      bytes_r <= item.end_of_line ? 5'd0 : bytes_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < glmf_pkg::PATTERN_MAX; k++) begin
        recent_r[k] <= win[k];
      end
    end
  end

  `GLMF_ASSERT_NEVER(a_bytes_bound, clk, rst_n, bytes_r > 5'(glmf_pkg::WINDOW_DEPTH))

endmodule

### sv/glmf_evq.sv
`include "grep_line_match_filter_core_defines.svh"

module glmf_evq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  glmf_pkg::match_evt_t wr_data,
  output logic                 full,
  input  logic                 rd_en,
  output glmf_pkg::match_evt_t rd_data,
  output logic                 empty
);

  localparam int PTR_W = $clog2(glmf_pkg::EVQ_DEPTH);

  glmf_pkg::match_evt_t mem_r [glmf_pkg::EVQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   count_r;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count_r == (PTR_W+1)'(glmf_pkg::EVQ_DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `GLMF_ASSERT_NEVER(a_count_bound, clk, rst_n, count_r > (PTR_W+1)'(glmf_pkg::EVQ_DEPTH))
  `GLMF_ASSERT(a_count_grows, clk, rst_n, (do_wr && !do_rd) |=> (count_r == $past(count_r) + 1'b1))

endmodule

### sv/glmf_back.sv
`include "grep_line_match_filter_core_defines.svh"

module glmf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  glmf_pkg::cfg_t       cfg,
  input  logic                 evt_avail,
  input  glmf_pkg::match_evt_t evt,
  output logic                 evt_take,
  output logic                 out_valid,
  output glmf_pkg::out_item_t  out_item,
  input  logic                 out_pop
);

  logic [15:0] line_r;
  logic        has_r;
  logic        pend_r;
  logic [7:0]  tally_r;
  logic        out_valid_r;
  glmf_pkg::out_item_t out_item_r;

  logic        out_free;
  logic        has_nxt;
  logic        pend_nxt;
  logic [7:0]  tally_nxt;

  assign out_free = !out_valid_r || out_pop;
  assign evt_take = evt_avail && (!evt.eol || out_free);

  // Line state after this byte: first settle a waiting word match, then the new one.
  always_comb begin
    has_nxt  = has_r || (pend_r && !evt.word_byte) || evt.empty_pat ||
               (evt.hit && !cfg.whole_word) ||
               (evt.hit && cfg.whole_word && evt.left_ok && evt.eol);
    pend_nxt = evt.hit && cfg.whole_word && evt.left_ok && !evt.eol;
    tally_nxt = (evt.hit && tally_r != 8'hFF) ? tally_r + 8'd1 : tally_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r      <= 16'd1;
      has_r       <= 1'b0;
      pend_r      <= 1'b0;
      tally_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (evt_take) begin
        if (evt.eol) begin
          line_r  <= (line_r != 16'hFFFF) ? line_r + 16'd1 : line_r;
          has_r   <= 1'b0;
          pend_r  <= 1'b0;
          tally_r <= '0;
        end else begin
          has_r   <= has_nxt;
          pend_r  <= pend_nxt;
          tally_r <= tally_nxt;
        end
      end
      // Result register is loaded at a line end and freed by a transfer.
      if (evt_take && evt.eol) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (evt_take && evt.eol) begin
      out_item_r.line_number      <= line_r;
      out_item_r.line_selected    <= has_nxt ^ cfg.invert_select;
      out_item_r.occurrence_count <= tally_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `GLMF_ASSERT_NEVER(a_line_nonzero, clk, rst_n, line_r == 16'd0)
  `GLMF_ASSERT(a_result_line, clk, rst_n, (evt_take && evt.eol) |=> (out_item_r.line_number == $past(line_r)))

endmodule

### sv/grep_line_match_filter_core.sv
// Fixed-string line matcher: one text byte per cycle unless full; a result per line end.
// Path: a line's end event passes through the event queue, then the result register.
// Throughput: 1 byte/cycle unless in_full; front-end window compare is fully parallel.
// A 4-entry event queue and the result register let input and output stall apart.
// Reset (rst_n low at a clock edge) clears configuration, line count to 1 and all queues.
module grep_line_match_filter_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  glmf_pkg::in_item_t                  in_data,
  output logic                                out_empty,
  input  logic                                out_pop,
  output glmf_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [glmf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [63:0]                         cfg_wdata
);

  glmf_pkg::cfg_t       cfg_r;
  glmf_pkg::match_evt_t front_evt;
  glmf_pkg::match_evt_t q_evt;
  logic                 in_accept;
  logic                 q_empty;
  logic                 evt_take;
  logic                 out_valid;
  logic                 out_xfer;

  assign in_accept = in_push && !in_full;
  assign out_empty = !out_valid;
  assign out_xfer  = out_pop && out_valid;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        glmf_pkg::CFG_PATTERN_LOW:  cfg_r.pattern[7:0]  <= cfg_wdata;
        glmf_pkg::CFG_PATTERN_HIGH: cfg_r.pattern[15:8] <= cfg_wdata;
        glmf_pkg::CFG_PATTERN_LEN:  cfg_r.pattern_length <= cfg_wdata[4:0];
        glmf_pkg::CFG_IGNORE_CASE:  cfg_r.ignore_case   <= cfg_wdata[0];
        glmf_pkg::CFG_WHOLE_WORD:   cfg_r.whole_word    <= cfg_wdata[0];
        glmf_pkg::CFG_INVERT:       cfg_r.invert_select <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  glmf_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .accept (in_accept),
    .item   (in_data),
    .evt    (front_evt)
  );

  glmf_evq u_evq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_accept),
    .wr_data (front_evt),
    .full    (in_full),
    .rd_en   (evt_take),
    .rd_data (q_evt),
    .empty   (q_empty)
  );

  glmf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .evt_avail (!q_empty),
    .evt       (q_evt),
    .evt_take  (evt_take),
    .out_valid (out_valid),
    .out_item  (out_data),
    .out_pop   (out_xfer)
  );

endmodule
